### sv/wlb_pkg.sv
package wlb_pkg;

  // Image geometry.
  localparam int IMAGE_WIDTH   = 32;
  localparam int IMAGE_HEIGHT  = 64;
  localparam int CHANNEL_COUNT = 4;

  // Item counts of one frame.
  localparam int FRAME_PIXELS = IMAGE_HEIGHT * IMAGE_WIDTH * CHANNEL_COUNT;
  localparam int RAMP_ITEMS   = (IMAGE_WIDTH + 1) * CHANNEL_COUNT;
  localparam int FRAME_ITEMS  = FRAME_PIXELS + RAMP_ITEMS;

  // Delay line: two image lines plus two window columns, all channels.
  localparam int LINE_ITEMS  = IMAGE_WIDTH * CHANNEL_COUNT;
  localparam int CHAIN_DEPTH = 2 * LINE_ITEMS + 2 * CHANNEL_COUNT;

  // Counter widths.
  localparam int CH_W   = ($clog2(CHANNEL_COUNT) > 2) ? $clog2(CHANNEL_COUNT) : 2;
  localparam int COL_W  = ($clog2(IMAGE_WIDTH) > 1) ? $clog2(IMAGE_WIDTH) : 1;
  localparam int ROW_W  = $clog2(IMAGE_HEIGHT + 1);
  localparam int ITEM_W = $clog2(FRAME_ITEMS);

  // Configuration register map.
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_ZERO_POINT = 1'b0;

  typedef logic [7:0] pixel_t;

  // Position of the current item, handed from the sequencer to the datapath.
  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             emit;
    logic             live_px;
    logic             last;
  } wlb_pos_t;

endpackage

### sv/wlb_cell.sv
module wlb_cell (
  input  logic            clk,
  input  logic            shift_en,
  input  wlb_pkg::pixel_t d,
  output wlb_pkg::pixel_t q
);

  wlb_pkg::pixel_t q_r;

  // One byte of the delay line; moves on every accepted request.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

### sv/wlb_seq.sv
module wlb_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  output wlb_pkg::wlb_pos_t pos
);

  logic [wlb_pkg::ITEM_W-1:0] item_r, item_nxt;
  logic [wlb_pkg::CH_W-1:0]   ch_r, ch_nxt;
  logic [wlb_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [wlb_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic                       ch_wrap;
  logic                       col_wrap;
  logic                       emit;
  logic                       last;

  assign ch_wrap  = (ch_r == wlb_pkg::CH_W'(wlb_pkg::CHANNEL_COUNT - 1));
  assign col_wrap = (col_r == wlb_pkg::COL_W'(wlb_pkg::IMAGE_WIDTH - 1));
  assign emit     = (item_r >= wlb_pkg::ITEM_W'(wlb_pkg::RAMP_ITEMS));
  assign last     = (item_r == wlb_pkg::ITEM_W'(wlb_pkg::FRAME_ITEMS - 1));

  // Next channel, output position and item count.
  always_comb begin
    item_nxt = item_r + 1'b1;
    ch_nxt   = ch_wrap ? '0 : ch_r + 1'b1;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (emit && ch_wrap) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
    if (last) begin
      item_nxt = '0;
      ch_nxt   = '0;
      col_nxt  = '0;
      row_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r <= '0;
      ch_r   <= '0;
      col_r  <= '0;
      row_r  <= '0;
    end else if (step) begin
      item_r <= item_nxt;
      ch_r   <= ch_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
    end
  end

  assign pos.ch      = ch_r;
  assign pos.col     = col_r;
  assign pos.row     = row_r;
  assign pos.emit    = emit;
  assign pos.live_px = (item_r < wlb_pkg::ITEM_W'(wlb_pkg::FRAME_PIXELS));
  assign pos.last    = last;

endmodule

### sv/window_3x3_line_buffer.sv
// Channel  Direction  Handshake                 Payload
// in_      input      in_valid / in_ready       in_pixel
// out_     output     out_valid / out_ready     out_tap_r0c0..r2c2, channel_index, frame_end
// cfg_     APB        psel & penable & pwrite   paddr, pwdata, prdata (zero_point)
//
// One request per cycle while in_ready is high; the output register holds each window.
// The first (IMAGE_WIDTH+1)*CHANNEL_COUNT requests of a frame only fill the delay line.
// The delay line is a chain of byte cells that shifts on every accepted request.
// in_ready drops only while a window waits in the output register and out_ready is low.
// Synchronous active-low reset clears the counters, the zero point and the output valid
// flag; the delay line keeps its bytes, which only ever reach padded taps.
module window_3x3_line_buffer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_pixel,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [7:0]                out_tap_r0c0,
  output logic signed [7:0]                out_tap_r0c1,
  output logic signed [7:0]                out_tap_r0c2,
  output logic signed [7:0]                out_tap_r1c0,
  output logic signed [7:0]                out_tap_r1c1,
  output logic signed [7:0]                out_tap_r1c2,
  output logic signed [7:0]                out_tap_r2c0,
  output logic signed [7:0]                out_tap_r2c1,
  output logic signed [7:0]                out_tap_r2c2,
  output logic [1:0]                       out_channel_index,
  output logic                             out_frame_end,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wlb_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  wlb_pkg::pixel_t   zero_point_r;
  wlb_pkg::pixel_t   px_eff;
  wlb_pkg::pixel_t   chain_q [wlb_pkg::CHAIN_DEPTH];
  wlb_pkg::pixel_t   win     [3][3];
  wlb_pkg::pixel_t   tap_nxt [3][3];
  wlb_pkg::pixel_t   tap_r   [3][3];
  wlb_pkg::wlb_pos_t pos;
  logic [1:0]        chan_r;
  logic              frame_end_r;
  logic              out_valid_r;
  logic              step;
  logic              row_ok  [3];
  logic              col_ok  [3];

  // Configuration port: single register decoded on paddr[2] alone; writes with paddr[2] set are dropped.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == wlb_pkg::REG_ZERO_POINT) ? {24'b0, zero_point_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_point_r <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == wlb_pkg::REG_ZERO_POINT)) begin
      zero_point_r <= pwdata[7:0];
    end
  end

  // Accept while the output register is free or being drained.
  assign in_ready = !out_valid_r || out_ready;
  assign step     = in_valid && in_ready;

  wlb_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .pos   (pos)
  );

  // Flush requests after the frame's pixels feed zeros.
  assign px_eff = pos.live_px ? in_pixel : '0;

  // Delay line of byte cells; stage k holds the pixel of k+1 requests ago.
  for (genvar k = 0; k < wlb_pkg::CHAIN_DEPTH; k++) begin : g_chain
    if (k == 0) begin : g_head
      wlb_cell u_cell (.clk(clk), .shift_en(step), .d(px_eff), .q(chain_q[k]));
    end else begin : g_body
      wlb_cell u_cell (.clk(clk), .shift_en(step), .d(chain_q[k-1]), .q(chain_q[k]));
    end
  end

  // Window taps: rows are one image line apart, columns one pixel (all channels) apart.
  for (genvar i = 0; i < 3; i++) begin : g_row
    localparam logic [wlb_pkg::ROW_W:0] RowOff = (wlb_pkg::ROW_W + 1)'(i);
    localparam logic [wlb_pkg::COL_W:0] ColOneOff = (wlb_pkg::COL_W + 1)'(i);
    logic [wlb_pkg::ROW_W:0] rsum;
    logic [wlb_pkg::COL_W:0] csum;

    // Row i and column i of the window, shifted by one so they stay unsigned.
    assign rsum = {1'b0, pos.row} + RowOff;
    assign csum = {1'b0, pos.col} + ColOneOff;
    assign row_ok[i] = (rsum != '0) &&
                       (rsum <= (wlb_pkg::ROW_W + 1)'(wlb_pkg::IMAGE_HEIGHT));
    assign col_ok[i] = (csum != '0) &&
                       (csum <= (wlb_pkg::COL_W + 1)'(wlb_pkg::IMAGE_WIDTH));

    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int Delay = (2 - i) * wlb_pkg::LINE_ITEMS + (2 - j) * wlb_pkg::CHANNEL_COUNT;
      if (Delay == 0) begin : g_now
        assign win[i][j] = px_eff;
      end else begin : g_past
        assign win[i][j] = chain_q[Delay-1];
      end
      assign tap_nxt[i][j] = (row_ok[i] && col_ok[j]) ? (win[i][j] - zero_point_r) : '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= pos.emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && pos.emit) begin
      tap_r       <= tap_nxt;
      chan_r      <= pos.ch[1:0];
      frame_end_r <= pos.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tap_r0c0      = tap_r[0][0];
  assign out_tap_r0c1      = tap_r[0][1];
  assign out_tap_r0c2      = tap_r[0][2];
  assign out_tap_r1c0      = tap_r[1][0];
  assign out_tap_r1c1      = tap_r[1][1];
  assign out_tap_r1c2      = tap_r[1][2];
  assign out_tap_r2c0      = tap_r[2][0];
  assign out_tap_r2c1      = tap_r[2][1];
  assign out_tap_r2c2      = tap_r[2][2];
  assign out_channel_index = chan_r;
  assign out_frame_end     = frame_end_r;

endmodule
